// ===== rtl/triaxis_swing_gesture_detector_assert.svh =====
// assertion macros used by the swing detector checker
`ifndef TRIAXIS_SWING_GESTURE_DETECTOR_ASSERT_SVH
`define TRIAXIS_SWING_GESTURE_DETECTOR_ASSERT_SVH

// clocked assertion, masked while reset is high
`define SGD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define SGD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/sgd_pkg.sv =====
// shared constants and types for the three-axis swing detector
package sgd_pkg;

   localparam int SAMPLE_BITS_DEF = 13;
   localparam int THR_W           = 13;
   localparam int PERIOD_W        = 15;
   localparam int COUNT_W         = 16;
   localparam int AXIS_W          = 2;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 2'd3;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam logic                       ENABLE_RST = 1'b1;
   localparam logic [THR_W-1:0]           THR_RST    = 13'd2500;
   localparam logic [PERIOD_W-1:0]        TICK_RST   = 15'd100;
   localparam logic [PERIOD_W-1:0]        HOLD_RST   = 15'd2000;
   localparam logic signed [COUNT_W-1:0]  COUNT_RST  = 16'sd2000;

   typedef struct packed {
      logic load;
      logic update;
   } axis_ctl_type;

   typedef struct packed {
      logic step;
      logic set;
   } hold_ctl_type;

   typedef struct packed {
      logic active;
      logic expired;
   } hold_stat_type;

endpackage

// ===== rtl/sgd_req_if.sv =====
// sample channel: valid, ready and the three axis readings
interface sgd_req_if #(
   parameter int SAMPLE_BITS = sgd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

// ===== rtl/sgd_rsp_if.sv =====
// result channel: valid, ready and the detection word
interface sgd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        detected;
   logic [sgd_pkg::AXIS_W-1:0]  detected_axis;
   logic                        hold_active;
   logic                        hold_expired;

   modport source (output valid, output detected, output detected_axis,
                   output hold_active, output hold_expired, input ready);
   modport sink   (input valid, input detected, input detected_axis,
                   input hold_active, input hold_expired, output ready);
endinterface

// ===== rtl/triaxis_swing_gesture_detector.sv =====
// Three-axis swing detector: one accelerometer word in, one detection word out.
// req_bus carries accel_x/y/z; a word is taken when valid and ready are high.
// rsp_bus returns detected, detected_axis, hold_active and hold_expired for
// every word taken, in order, one result per word.
// A word taken loads the input register and then the result register, which
// drives rsp_bus. Throughput: one word per cycle while rsp_ready is high; the
// min/max compare and countdown subtract sit between the input register and
// the result register.
// The csr_ port writes enable, swing_threshold, tick_period and hold_time
// (index 0..3) on any edge with csr_we high; write only while idle.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults, re-arms the min/max init and clears the hold.
// When rsp_ready is low, the result register holds its word and the input
// register still takes one more word before req_ready drops.
module triaxis_swing_gesture_detector #(
   parameter int SAMPLE_BITS = sgd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   sgd_req_if.sink                           req_bus,
   sgd_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [sgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sgd_pkg::*;

   // configuration
   logic                enable_ff;
   logic [THR_W-1:0]    threshold_ff;
   logic [PERIOD_W-1:0] tick_ff;
   logic [PERIOD_W-1:0] hold_ff;

   // input register
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;

   // result register
   logic                out_valid_ff;
   logic                det_ff;
   logic [AXIS_W-1:0]   axis_ff;
   logic                active_ff;
   logic                expired_ff;

   logic                init_pending_ff, init_pending_in;
   logic                out_free, s1_fire, req_fire, step;
   logic                exceed_x, exceed_y, exceed_z;
   logic                det;
   logic [AXIS_W-1:0]   det_axis;
   axis_ctl_type        axis_ctl;
   hold_ctl_type        hold_ctl;
   hold_stat_type       hold_stat;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign step          = s1_fire && enable_ff;

   assign axis_ctl.load   = step && init_pending_ff;
   assign axis_ctl.update = step && !init_pending_ff;

   sgd_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .clock(clock), .ctl(axis_ctl), .sample(s1_x_ff),
      .threshold(threshold_ff), .exceed(exceed_x)
   );
   sgd_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .clock(clock), .ctl(axis_ctl), .sample(s1_y_ff),
      .threshold(threshold_ff), .exceed(exceed_y)
   );
   sgd_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_z (
      .clock(clock), .ctl(axis_ctl), .sample(s1_z_ff),
      .threshold(threshold_ff), .exceed(exceed_z)
   );

   // x wins over y, y over z
   always_comb begin
      det      = 1'b0;
      det_axis = AXIS_X;
      if (axis_ctl.update) begin
         if (exceed_x) begin
            det      = 1'b1;
            det_axis = AXIS_X;
         end else if (exceed_y) begin
            det      = 1'b1;
            det_axis = AXIS_Y;
         end else if (exceed_z) begin
            det      = 1'b1;
            det_axis = AXIS_Z;
         end
      end
   end

   assign hold_ctl.step = step;
   assign hold_ctl.set  = det;

   sgd_hold u_hold (
      .clock(clock), .reset(reset), .ctl(hold_ctl),
      .tick_period(tick_ff), .hold_time(hold_ff), .stat(hold_stat)
   );

   always_comb begin
      init_pending_in = init_pending_ff;
      if (axis_ctl.load) begin
         init_pending_in = 1'b0;
      end else if (det) begin
         init_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= ENABLE_RST;
         threshold_ff <= THR_RST;
         tick_ff      <= TICK_RST;
         hold_ff      <= HOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_TICK:      tick_ff      <= csr_wdata[PERIOD_W-1:0];
            CSR_HOLD:      hold_ff      <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         init_pending_ff <= 1'b1;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         init_pending_ff <= init_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff <= req_bus.accel_x;
         s1_y_ff <= req_bus.accel_y;
         s1_z_ff <= req_bus.accel_z;
      end
      if (s1_fire) begin
         det_ff     <= det;
         axis_ff    <= det_axis;
         active_ff  <= hold_stat.active;
         expired_ff <= hold_stat.expired;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.detected      = det_ff;
   assign rsp_bus.detected_axis = axis_ff;
   assign rsp_bus.hold_active   = active_ff;
   assign rsp_bus.hold_expired  = expired_ff;

endmodule

// ===== rtl/sgd_axis.sv =====
// per-axis running min/max tracker with span threshold compare
module sgd_axis #(
   parameter int SAMPLE_BITS = sgd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  sgd_pkg::axis_ctl_type         ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [sgd_pkg::THR_W-1:0]     threshold,
   output logic                          exceed
);
   import sgd_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;

   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic signed [SAMPLE_BITS:0]   hi_ext, lo_ext, diff;
   logic [SAMPLE_BITS:0]          span;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctl.load) begin
         lo_in = sample;
         hi_in = sample;
      end else if (ctl.update) begin
         if (sample > hi_ff) begin
            hi_in = sample;
         end else if (sample < lo_ff) begin
            lo_in = sample;
         end
      end
   end

   // min never exceeds max, so the span is non-negative
   assign hi_ext = (SAMPLE_BITS+1)'(hi_in);
   assign lo_ext = (SAMPLE_BITS+1)'(lo_in);
   assign diff   = hi_ext - lo_ext;
   assign span   = $unsigned(diff);
   assign exceed = CMP_W'(span) > CMP_W'(threshold);

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule

// ===== rtl/sgd_hold.sv =====
// hold flag and millisecond countdown after a detection
module sgd_hold (
   input  logic                          clock,
   input  logic                          reset,
   input  sgd_pkg::hold_ctl_type         ctl,
   input  logic [sgd_pkg::PERIOD_W-1:0]  tick_period,
   input  logic [sgd_pkg::PERIOD_W-1:0]  hold_time,
   output sgd_pkg::hold_stat_type        stat
);
   import sgd_pkg::*;

   logic                      flag_ff, flag_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic signed [COUNT_W:0]   diff;
   logic                      run_out;
   logic                      expired;

   assign diff    = $signed({count_ff[COUNT_W-1], count_ff}) - $signed({2'b00, tick_period});
   assign run_out = diff[COUNT_W] || (diff == '0);

   always_comb begin
      flag_in  = flag_ff;
      count_in = count_ff;
      expired  = 1'b0;
      // detection raises the flag and the countdown drops on the same tick, unless the count runs out
      if (ctl.step && (flag_ff || ctl.set)) begin
         if (run_out) begin
            flag_in  = 1'b0;
            count_in = $signed(COUNT_W'(hold_time));
            expired  = 1'b1;
         end else begin
            flag_in  = 1'b1;
            count_in = $signed(diff[COUNT_W-1:0]);
         end
      end
   end

   assign stat.active  = flag_in;
   assign stat.expired = expired;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 1'b0;
         count_ff <= COUNT_RST;
      end else begin
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/sgd_checker.sv =====
// port-level checks for the swing detector, bound to the top level
`include "triaxis_swing_gesture_detector_assert.svh"

module sgd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        detected,
   input logic [sgd_pkg::AXIS_W-1:0]  detected_axis,
   input logic                        hold_active,
   input logic                        hold_expired
);
   import sgd_pkg::*;

   // no detection reports the x code
   `SGD_ASSERT(a_axis_idle, clock, reset, rsp_valid && !detected |-> detected_axis == AXIS_X, "axis set without detection")

   // an expiring hold leaves the flag down
   `SGD_ASSERT(a_expire_drops, clock, reset, rsp_valid && hold_expired |-> !hold_active, "hold active after expiry")

   // a detection that does not expire leaves the hold up
   `SGD_ASSERT(a_detect_holds, clock, reset, rsp_valid && detected && !hold_expired |-> hold_active, "detection without hold")

   `SGD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(detected) && $stable(detected_axis) && $stable(hold_active) && $stable(hold_expired), "stalled result changed")

   // reset empties the result register
   `SGD_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind triaxis_swing_gesture_detector sgd_checker u_sgd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .detected      (rsp_bus.detected),
   .detected_axis (rsp_bus.detected_axis),
   .hold_active   (rsp_bus.hold_active),
   .hold_expired  (rsp_bus.hold_expired)
);
